// ===== rtl/mpba_pkg.sv =====
// Shared types, constants and command/status structs for the block pool allocator.
package mpba_pkg;

  localparam int unsigned PoolLimit = 5;
  localparam int unsigned HeapBytes = 65536;
  localparam int unsigned PoolW     = $clog2(PoolLimit);
  localparam int unsigned AddrW     = 16;
  localparam int unsigned SizeW     = 17;
  localparam int unsigned CntW      = 3;
  localparam int unsigned RegIdxW   = 3;

  // Register indexes
  localparam logic [RegIdxW-1:0] RegPoolCount = 3'd0;
  localparam logic [RegIdxW-1:0] RegSizeA     = 3'd1;
  localparam logic [RegIdxW-1:0] RegSizeE     = 3'd5;

  // Result status codes
  localparam logic [2:0] StAlloc     = 3'd0;
  localparam logic [2:0] StNoFit     = 3'd1;
  localparam logic [2:0] StZeroSize  = 3'd2;
  localparam logic [2:0] StFreed     = 3'd3;
  localparam logic [2:0] StFreeUnkn  = 3'd4;
  localparam logic [2:0] StCfgBad    = 3'd5;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;    // capture input item
    logic div_start;    // start the shared divider
    logic mul_start;    // register bump address and default alloc result
    logic cfg_step;     // advance pool derivation by one pool
    logic cfg_clear;    // restart pool derivation
    logic do_alloc;     // alloc decision cycle
    logic do_free;      // free decision cycle
    logic link_rd;      // read link store at popped head
    logic pop_commit;   // commit link read into free head
    logic free_scan;    // check one pool for a free hit
    logic scan_clear;   // reset free scan
  } mpba_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_busy;
    logic cfg_done;
    logic cfg_ok;
    logic kind;
    logic scan_done;
    logic need_pop;
  } mpba_sts_t;

endpackage

// ===== rtl/mpba_divider.sv =====
// Shared iterative unsigned divider, one quotient bit per cycle.
module mpba_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mpba_pkg::SizeW-1:0] dividend_i,
  input  logic [mpba_pkg::SizeW-1:0] divisor_i,
  output logic                      busy_o,
  output logic [mpba_pkg::SizeW-1:0] quot_o,
  output logic [mpba_pkg::SizeW-1:0] rem_o
);
  import mpba_pkg::*;

  localparam int unsigned StepW = $clog2(SizeW + 1);

  logic [SizeW-1:0] quot_q, quot_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [SizeW-1:0] dvs_q;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic [SizeW:0]   trial;

  // One restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    trial  = {rem_q, quot_q[SizeW-1]};
    quot_d = quot_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = SizeW'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[SizeW-2:0], 1'b1};
      end else begin
        rem_d = trial[SizeW-1:0];
        quot_d = {quot_q[SizeW-2:0], 1'b0};
      end
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepW'(SizeW);
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/mpba_datapath.sv =====
// Datapath: config registers, pool geometry, counters, free lists and link store.
module mpba_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mpba_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [mpba_pkg::SizeW-1:0]   cfg_data_i,
  input  logic                        kind_i,
  input  logic [mpba_pkg::SizeW-1:0]   request_size_i,
  input  logic [mpba_pkg::AddrW-1:0]   block_address_i,
  input  mpba_pkg::mpba_cmd_t          cmd_i,
  output mpba_pkg::mpba_sts_t          sts_o,
  output logic                        res_granted_o,
  output logic [mpba_pkg::AddrW-1:0]   res_address_o,
  output logic [2:0]                  res_status_o
);
  import mpba_pkg::*;

  // Configuration registers
  logic [CntW-1:0]  pool_count_q;
  logic [SizeW-1:0] size_q [PoolLimit];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_count_q <= CntW'(1);
      for (int i = 0; i < PoolLimit; i++) size_q[i] <= (i == 0) ? SizeW'(64) : '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegPoolCount) pool_count_q <= cfg_data_i[CntW-1:0];
      else if (cfg_idx_i >= RegSizeA && cfg_idx_i <= RegSizeE)
        size_q[PoolW'(cfg_idx_i - RegSizeA)] <= cfg_data_i;
    end
  end

  // Item capture
  logic             kind_q;
  logic [SizeW-1:0] req_q;
  logic [AddrW-1:0] addr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= kind_i;
      req_q  <= request_size_i;
      addr_q <= block_address_i;
    end
  end

  // Shared divider: partition / size during config, (addr-base) % size on free
  logic             div_busy;
  logic [SizeW-1:0] div_q, div_r, div_a, div_b;
  logic [PoolW-1:0] cpool_q;   // pool under derivation
  logic [SizeW-1:0] partition;
  logic             cfg_bad_cnt;
  logic [PoolW-1:0] spool_q;   // pool under free scan
  logic             cfg_ok_q, cfg_done_q, cfg_fail_q;

  assign cfg_bad_cnt = (pool_count_q == '0) || (pool_count_q > CntW'(PoolLimit));
  // Partition per pool count, a small constant table
  always_comb begin
    case (pool_count_q)
      3'd1:    partition = SizeW'(HeapBytes);
      3'd2:    partition = SizeW'(HeapBytes / 2);
      3'd3:    partition = SizeW'(HeapBytes / 3);
      3'd4:    partition = SizeW'(HeapBytes / 4);
      3'd5:    partition = SizeW'(HeapBytes / 5);
      default: partition = '0;
    endcase
  end

  logic [SizeW-1:0] base_q [PoolLimit];
  logic [SizeW-1:0] cap_q  [PoolLimit];
  logic [SizeW-1:0] used_q [PoolLimit];
  logic [SizeW-1:0] head_q [PoolLimit];

  always_comb begin
    if (cfg_done_q) begin
      div_a = SizeW'(addr_q) - base_q[spool_q];
      div_b = size_q[spool_q];
    end else begin
      div_a = partition;
      div_b = size_q[cpool_q];
    end
  end

  mpba_divider u_div (
    .clk_i, .rst_ni,
    .start_i   (cmd_i.div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .busy_o    (div_busy),
    .quot_o    (div_q),
    .rem_o     (div_r)
  );

  // Pool derivation: one pool per divide, then a multiply for the span added into the cursor register
  logic [SizeW-1:0] cursor_q;
  logic [33:0]      span;
  logic             cur_bad;
  logic             last_pool;

  assign cur_bad   = (size_q[cpool_q] == '0) || (size_q[cpool_q] > partition);
  assign last_pool = ({1'b0, cpool_q} + 4'd1) >= {1'b0, pool_count_q};
  assign span      = 34'(div_q) * 34'(size_q[cpool_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpool_q    <= '0;
      cfg_done_q <= 1'b0;
      cfg_ok_q   <= 1'b0;
      cfg_fail_q <= 1'b0;
      cursor_q   <= '0;
    end else if (cmd_i.cfg_clear) begin
      cpool_q    <= '0;
      cursor_q   <= '0;
      cfg_ok_q   <= 1'b0;
      cfg_fail_q <= cfg_bad_cnt;
      cfg_done_q <= cfg_bad_cnt;
    end else if (cmd_i.cfg_step) begin
      if (cur_bad) begin
        cfg_done_q <= 1'b1;
        cfg_fail_q <= 1'b1;
      end else begin
        cursor_q <= cursor_q + span[SizeW-1:0];
        if (last_pool) begin
          cfg_done_q <= 1'b1;
          cfg_ok_q   <= 1'b1;
        end else cpool_q <= cpool_q + PoolW'(1);
      end
    end
  end

  // Base and capacity per pool
  always_ff @(posedge clk_i) begin
    if (cmd_i.cfg_step && !cur_bad) begin
      base_q[cpool_q] <= cursor_q;
      cap_q[cpool_q]  <= div_q;
    end
  end

  // Allocation choice over the active pools
  logic [PoolLimit-1:0] room, fit;
  logic             found;
  logic [PoolW-1:0] pick;
  logic [SizeW-1:0] best;
  logic [PoolLimit-1:0] hvalid_q;
  always_comb begin
    found = 1'b0;
    pick  = '0;
    best  = '0;
    for (int i = 0; i < PoolLimit; i++) begin
      room[i] = (used_q[i] < cap_q[i]) || hvalid_q[i];
      fit[i]  = (CntW'(i) < pool_count_q) && room[i] && (req_q <= size_q[i]);
      if (fit[i] && (!found || size_q[i] <= best)) begin
        found = 1'b1;
        best  = size_q[i];
        pick  = PoolW'(i);
      end
    end
  end

  // Bump address product, registered before use
  logic [33:0]      bump;
  logic [SizeW-1:0] bump_q;
  logic [PoolW-1:0] pick_q;
  assign bump = 34'(used_q[pick]) * 34'(size_q[pick]);
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      bump_q <= base_q[pick] + bump[SizeW-1:0];
      pick_q <= pick;
    end
  end

  // Free scan: one pool per divide, last hit wins
  logic             hit_q;
  logic [PoolW-1:0] hit_pool_q;
  logic             in_range;
  logic [SizeW-1:0] hi_lim;
  logic [33:0]      hspan;
  assign hspan    = 34'(cap_q[spool_q]) * 34'(size_q[spool_q]);
  assign hi_lim   = base_q[spool_q] + hspan[SizeW-1:0];
  assign in_range = (SizeW'(addr_q) >= base_q[spool_q]) && (SizeW'(addr_q) < hi_lim);

  // Link store, a memory with registered read
  logic [SizeW-1:0] link_mem [HeapBytes];
  logic [SizeW-1:0] link_rd_q;
  logic             link_we;
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[addr_q] <= {hvalid_q[hit_pool_q], head_q[hit_pool_q][AddrW-1:0]};
    if (cmd_i.link_rd) link_rd_q <= link_mem[head_q[pick_q][AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spool_q    <= '0;
      hit_q      <= 1'b0;
      hit_pool_q <= '0;
    end else if (cmd_i.scan_clear) begin
      spool_q <= '0;
      hit_q   <= 1'b0;
    end else if (cmd_i.free_scan) begin
      if (in_range && div_r == '0) begin
        hit_q      <= 1'b1;
        hit_pool_q <= spool_q;
      end
      spool_q <= spool_q + PoolW'(1);
    end
  end

  logic scan_done;
  logic pop_en;
  assign scan_done = ({1'b0, spool_q} + 4'd1) >= {1'b0, pool_count_q};
  assign link_we   = cmd_i.do_free && hit_q;
  // Of the allocations, only a block taken from the free list moves the head
  assign pop_en    = cmd_i.pop_commit && hvalid_q[pick_q];

  // Counters and free list heads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
      for (int i = 0; i < PoolLimit; i++) used_q[i] <= '0;
    end else if (cmd_i.cfg_clear) begin
      hvalid_q <= '0;
      for (int i = 0; i < PoolLimit; i++) used_q[i] <= '0;
    end else begin
      if (cmd_i.do_alloc && !hvalid_q[pick_q]) used_q[pick_q] <= used_q[pick_q] + SizeW'(1);
      if (pop_en) hvalid_q[pick_q] <= link_rd_q[AddrW];
      if (link_we) hvalid_q[hit_pool_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_en) head_q[pick_q] <= SizeW'(link_rd_q[AddrW-1:0]);
    if (link_we) head_q[hit_pool_q] <= SizeW'(addr_q);
  end

  // Result register
  logic [SizeW-1:0] got;
  assign got = hvalid_q[pick_q] ? head_q[pick_q] : bump_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      res_granted_o <= 1'b0;
      res_address_o <= '0;
      res_status_o  <= StCfgBad;
    end else if (cmd_i.mul_start) begin
      res_granted_o <= 1'b0;
      res_address_o <= '0;
      res_status_o  <= (req_q == '0) ? StZeroSize : StNoFit;
    end else if (cmd_i.do_alloc) begin
      res_granted_o <= 1'b1;
      res_address_o <= got[AddrW-1:0];
      res_status_o  <= StAlloc;
    end else if (cmd_i.do_free) begin
      res_granted_o <= hit_q;
      res_address_o <= '0;
      res_status_o  <= hit_q ? StFreed : StFreeUnkn;
    end
  end

  assign sts_o.div_busy  = div_busy;
  assign sts_o.cfg_done  = cfg_done_q;
  assign sts_o.cfg_ok    = cfg_ok_q && !cfg_fail_q;
  assign sts_o.kind      = kind_q;
  assign sts_o.scan_done = scan_done;
  assign sts_o.need_pop  = found && (req_q != '0);

  // Note: once derivation is done the divider operands follow the free scan
  // (address minus base over the scanned pool's size).
  logic unused_spool_path;
  assign unused_spool_path = ^span[33:SizeW] ^ ^bump[33:SizeW] ^ ^hspan[33:SizeW];

endmodule

// ===== rtl/mpba_ctrl.sv =====
// Controller state machine sequencing configuration derivation and requests.
module mpba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  mpba_pkg::mpba_sts_t sts_i,
  output mpba_pkg::mpba_cmd_t cmd_o
);
  import mpba_pkg::*;

  typedef enum logic [3:0] {
    S_CFG_CLR, S_CFG_DIV, S_CFG_WAIT, S_IDLE, S_DECIDE, S_ALLOC, S_POP_RD,
    S_POP_WB, S_SCAN_DIV, S_SCAN_WAIT, S_FREE, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_CFG_CLR: begin
        cmd_o.cfg_clear = 1'b1;
        state_d = S_CFG_DIV;
      end
      S_CFG_DIV: begin
        if (sts_i.cfg_done) state_d = S_IDLE;
        else begin
          cmd_o.div_start = 1'b1;
          state_d = S_CFG_WAIT;
        end
      end
      S_CFG_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.cfg_step = 1'b1;
          state_d = S_CFG_DIV;
        end
      end
      S_IDLE: begin
        if (in_valid_i && !out_valid_q) begin
          cmd_o.load_item = 1'b1;
          state_d = sts_i.cfg_ok ? S_DECIDE : S_OUT;
        end
      end
      S_DECIDE: begin
        cmd_o.scan_clear = 1'b1;
        if (sts_i.kind) begin
          state_d = S_SCAN_DIV;
        end else begin
          cmd_o.mul_start = 1'b1;
          state_d = sts_i.need_pop ? S_ALLOC : S_OUT;
        end
      end
      S_ALLOC: begin
        cmd_o.do_alloc = 1'b1;
        cmd_o.link_rd  = 1'b1;
        state_d = S_POP_RD;
      end
      S_POP_RD: state_d = S_POP_WB;
      S_POP_WB: begin
        cmd_o.pop_commit = 1'b1;
        state_d = S_OUT;
      end
      S_SCAN_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.free_scan = 1'b1;
          state_d = sts_i.scan_done ? S_FREE : S_SCAN_DIV;
        end
      end
      S_FREE: begin
        cmd_o.do_free = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) state_d = S_CFG_CLR;
  end

  // pop commit is issued in the write-back state; it moves the head only when the pool's list was used
  logic pop_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CFG_CLR;
      out_valid_q <= 1'b0;
      pop_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pop_q       <= (state_q == S_POP_RD);
    end
  end

  assign in_stall_o  = !(state_q == S_IDLE && !out_valid_q);
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o || $past(out_stall_i))
    else $error("item accepted while previous result pending");
  a_out_after_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !cfg_we_i) |=> out_valid_o)
    else $error("result not presented");
  a_pop_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_q |-> $past(state_q == S_POP_RD))
    else $error("pop write-back out of order");
`endif

endmodule

// ===== rtl/multi_pool_block_allocator.sv =====
// Top level of the segregated fixed-size block pool allocator.
// Usage:
//   Input channel: kind_i, request_size_i, block_address_i with in_valid_i and
//   in_stall_o. One result item per accepted request, on out_valid_o/out_stall_i
//   with granted_o, result_address_o and status_o, unless a cfg write aborts it.
//   Configuration: cfg_we_i, cfg_idx_i (0 pool count, 1..5 block sizes), cfg_data_i.
//   A write rebuilds the pools, and no request is taken meanwhile: a clear state,
//   then per active pool a start, a bit-serial divide and a step, then a closing
//   state; a bad pool count goes straight to the closing state.
// Sequence after acceptance: an allocate passes decide (with a registered bump
//   address from a multiply), alloc with a registered link store read, pop read,
//   free list write-back and output; no fit or zero size goes from decide to output; bad config goes to output.
//   A free passes decide, then per active pool a divide on the shared
//   bit-serial divider that checks block alignment, then free and output. One item is in flight at a
//   time; the next item is taken the cycle after the result leaves.
// Reset: registers return to one pool of 64-byte blocks and the pools are
//   derived as after a write; free lists and counters are empty.
// Stall: a result waits in the output register while out_stall_i is high and
//   no new item is accepted until it is taken.
module multi_pool_block_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mpba_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [mpba_pkg::SizeW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [mpba_pkg::SizeW-1:0]   request_size_i,
  input  logic [mpba_pkg::AddrW-1:0]   block_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        granted_o,
  output logic [mpba_pkg::AddrW-1:0]   result_address_o,
  output logic [2:0]                  status_o
);
  import mpba_pkg::*;

  mpba_cmd_t cmd;
  mpba_sts_t sts;

  mpba_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .in_valid_i, .in_stall_o,
    .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  mpba_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .kind_i, .request_size_i, .block_address_i,
    .cmd_i(cmd), .sts_o(sts),
    .res_granted_o(granted_o),
    .res_address_o(result_address_o),
    .res_status_o (status_o)
  );

endmodule

// ===== tb/tb.sv =====
// Testbench for the multi-pool block allocator: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import mpba_pkg::*;

  localparam bit KindAlloc = 1'b0;
  localparam bit KindFree  = 1'b1;
  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 120;

  typedef struct packed {
    bit        granted;
    bit [15:0] addr;
    bit [2:0]  status;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx_i = '0;
  logic [SizeW-1:0]    cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                kind_i = 1'b0;
  logic [SizeW-1:0]    request_size_i = '0;
  logic [AddrW-1:0]    block_address_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                granted_o;
  logic [AddrW-1:0]    result_address_o;
  logic [2:0]          status_o;

  multi_pool_block_allocator dut (.*);

  always #2 clk_i = ~clk_i;

  // Allocator state as the predictor sees it
  int        reg_count;
  int        reg_size [5];
  bit        pools_ok;
  int        pool_sz [5];
  int        pool_lo [5];
  int        pool_cap [5];
  int        used_cnt [5];
  bit        head_ok [5];
  bit [15:0] head_addr [5];
  bit [16:0] link_mem [65536];

  outcome_t  expected_q[$];
  bit [15:0] live_blocks[$];
  int        errors, cycles, n_items, n_results, n_allocs, n_frees;
  bit        stall_on;
  int        stall_left;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Recompute pool geometry; every register write also empties all pools
  function automatic void rebuild_pools();
    int part, cursor;
    cursor = 0;
    pools_ok = 1'b0;
    for (int i = 0; i < 5; i++) begin
      used_cnt[i] = 0; head_ok[i] = 1'b0; head_addr[i] = '0;
      pool_sz[i] = 0; pool_lo[i] = 0; pool_cap[i] = 0;
    end
    live_blocks.delete();
    if (reg_count == 0 || reg_count > 5) return;
    part = HeapBytes / reg_count;
    for (int i = 0; i < reg_count; i++) begin
      if (reg_size[i] == 0 || reg_size[i] > part) return;
      pool_sz[i] = reg_size[i];
      pool_lo[i] = cursor;
      pool_cap[i] = part / reg_size[i];
      cursor += pool_cap[i] * reg_size[i];
    end
    pools_ok = 1'b1;
  endfunction

  function automatic outcome_t allocate_or_free(bit kind, int req, bit [15:0] addr);
    outcome_t o;
    bit found;
    int pick, best, lo, hi, got;
    o = '0;
    found = 1'b0;
    pick = 0;
    best = 0;
    if (!pools_ok) begin
      o.status = StCfgBad;
      return o;
    end
    if (kind == KindAlloc) begin
      if (req == 0) begin
        o.status = StZeroSize;
        return o;
      end
      // smallest fitting pool with room, later pool wins a tie
      for (int i = 0; i < reg_count; i++) begin
        if ((used_cnt[i] < pool_cap[i] || head_ok[i]) && req <= pool_sz[i] &&
            (!found || pool_sz[i] <= best)) begin
          found = 1'b1; best = pool_sz[i]; pick = i;
        end
      end
      if (!found) begin
        o.status = StNoFit;
        return o;
      end
      if (head_ok[pick]) begin
        got = head_addr[pick];
        head_ok[pick] = link_mem[got][16];
        head_addr[pick] = link_mem[got][15:0];
      end else begin
        got = pool_lo[pick] + used_cnt[pick] * pool_sz[pick];
        used_cnt[pick]++;
      end
      o.granted = 1'b1;
      o.addr = got[15:0];
      o.status = StAlloc;
      return o;
    end
    // free: last pool whose range holds an aligned offset
    for (int i = 0; i < reg_count; i++) begin
      lo = pool_lo[i];
      hi = lo + pool_cap[i] * pool_sz[i];
      if (addr >= lo && addr < hi && pool_sz[i] != 0 && (addr - lo) % pool_sz[i] == 0) begin
        found = 1'b1; pick = i;
      end
    end
    if (!found) begin
      o.status = StFreeUnkn;
      return o;
    end
    link_mem[addr] = {head_ok[pick], head_addr[pick]};
    head_ok[pick] = 1'b1;
    head_addr[pick] = addr;
    o.granted = 1'b1;
    o.status = StFreed;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // Send one item after a random gap; predict it once accepted
  task automatic send_item(bit kind, int req, bit [15:0] addr);
    int gap;
    outcome_t o;
    gap = gap_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i <= kind;
    request_size_i <= req[16:0];
    block_address_i <= addr;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    o = allocate_or_free(kind, req, addr);
    expected_q.push_back(o);
    n_items++;
    if (o.granted && kind == KindAlloc) begin
      live_blocks.push_back(o.addr);
      n_allocs++;
    end
    if (o.granted && kind == KindFree) n_frees++;
  endtask

  // Wait until every expected result has come back, then let the block settle
  task automatic drain(int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[16:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegPoolCount) reg_count = value & 7;
    else reg_size[idx - RegSizeA] = value;
    rebuild_pools();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_pools(int count, int sa, int sb, int sc, int sd, int se);
    int sizes [5];
    sizes = '{sa, sb, sc, sd, se};
    drain(SettleCycles);
    for (int i = 0; i < 5; i++) write_reg(RegIdxW'(RegSizeA + i), sizes[i]);
    write_reg(RegPoolCount, count);
  endtask

  // Result checker: oldest expectation against each accepted result
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("MISMATCH unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (granted_o !== want.granted) report_mismatch("granted", granted_o, want.granted);
        if (result_address_o !== want.addr)
          report_mismatch("result_address", result_address_o, want.addr);
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
      end
    end
  end

  // Receiver stalls in bursts
  always @(negedge clk_i) begin
    if (!stall_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      out_stall_i <= (stall_left > 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Default pool: zero size, too large, offset zero, misaligned and double free
  task automatic test_directed();
    stall_on = 1'b0;
    send_item(KindAlloc, 0, 16'h0);
    send_item(KindAlloc, 1, 16'h0);
    send_item(KindAlloc, 64, 16'hffff);
    send_item(KindAlloc, 65, 16'h0);
    send_item(KindAlloc, 65536, 16'h0);
    send_item(KindFree, 0, 16'h0);
    send_item(KindFree, 1, 16'd63);
    send_item(KindFree, 0, 16'hffff);
    send_item(KindFree, 65536, 16'd65472);
    send_item(KindAlloc, 64, 16'h0);
    send_item(KindAlloc, 33, 16'h0);
    send_item(KindAlloc, 2, 16'h0);
    send_item(KindFree, 0, 16'd64);
    send_item(KindFree, 0, 16'd64);
    send_item(KindAlloc, 64, 16'h0);
    send_item(KindAlloc, 64, 16'h0);
    send_item(KindAlloc, 7, 16'h0);
    stall_on = 1'b1;
    send_item(KindFree, 0, 16'd128);
    send_item(KindAlloc, 64, 16'h0);
  endtask

  // Mixed traffic: mostly allocates and frees of live blocks, some noise
  task automatic test_traffic(int n);
    int r, req, p, k;
    bit [15:0] addr;
    stall_on = $urandom_range(0, 2) != 0;
    for (int i = 0; i < n; i++) begin
      if (i % 97 == 96) drain(0);
      if (i % 150 == 75) stall_on = ~stall_on;
      r = $urandom_range(0, 99);
      p = (reg_count >= 1 && reg_count <= 5) ? $urandom_range(0, reg_count - 1) : 0;
      if (r < 55) begin
        k = $urandom_range(0, 9);
        if (k < 4) req = reg_size[p] - $urandom_range(0, 3);
        else if (k < 8) req = $urandom_range(1, 256);
        else if (k < 9) req = $urandom_range(0, 65536);
        else req = reg_size[p] + 1;
        if (req < 0) req = 0;
        if (req > 65536) req = 65536;
        send_item(KindAlloc, req, 16'($urandom));
      end else begin
        k = $urandom_range(0, 9);
        if (k < 6 && live_blocks.size() != 0) begin
          p = $urandom_range(0, live_blocks.size() - 1);
          addr = live_blocks[p];
          if ($urandom_range(0, 4) != 0) live_blocks.delete(p);
        end else if (k < 8 && pool_cap[p] != 0) begin
          addr = 16'(pool_lo[p] + $urandom_range(0, pool_cap[p] - 1) * pool_sz[p]
                     + ($urandom_range(0, 3) == 0));
        end else begin
          addr = 16'($urandom);
        end
        send_item(KindFree, $urandom_range(0, 65536), addr);
      end
    end
  endtask

  task automatic test_pool_settings();
    set_pools(3, 100, 7, 100, 0, 0);
    test_traffic(260);
    set_pools(5, 13107, 13107, 1, 4096, 13107);
    test_traffic(260);
    set_pools(0, 64, 64, 64, 64, 64);
    test_traffic(30);
    set_pools(1, 65536, 5, 9, 11, 65536);
    test_traffic(200);
    set_pools(7, 64, 64, 64, 64, 64);
    test_traffic(30);
    set_pools(2, 0, 128, 1, 1, 1);
    test_traffic(30);
    set_pools(4, 16, 32, 16385, 8, 1);
    test_traffic(30);
    set_pools(5, 1, 2, 3, 5, 8);
    test_traffic(280);
    set_pools(2, 3000, 1000, 0, 0, 0);
    test_traffic(280);
    set_pools(4, 16384, 16384, 16384, 16384, 0);
    test_traffic(200);
    set_pools(1, 64, 0, 0, 0, 0);
    test_traffic(330);
  endtask

  initial begin
    reg_count = 1;
    reg_size = '{64, 0, 0, 0, 0};
    rebuild_pools();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (SettleCycles) @(posedge clk_i);
    test_directed();
    test_pool_settings();
    drain(SettleCycles);
    $display("Covered %0d requests over 11 pool settings incl. invalid ones: %0d results,",
             n_items, n_results);
    $display("%0d blocks allocated, %0d blocks freed, %0d mismatches.",
             n_allocs, n_frees, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== multi_pool_block_allocator.f =====
rtl/mpba_pkg.sv
rtl/mpba_divider.sv
rtl/mpba_datapath.sv
rtl/mpba_ctrl.sv
rtl/multi_pool_block_allocator.sv
tb/tb.sv
